// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the base64 encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define B64E_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define B64E_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define B64E_ASSERT(label, clk, rst_n, prop)
`define B64E_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/b64e_pkg.sv -----
// Types, constants and the symbol map for the base64 encoder.
package b64e_pkg;

    localparam int MAX_CHARS = 6;

    localparam logic [1:0] REG_CHAR_62  = 2'd0;
    localparam logic [1:0] REG_CHAR_63  = 2'd1;
    localparam logic [1:0] REG_PAD_EN   = 2'd2;
    localparam logic [1:0] REG_WRAP     = 2'd3;

    localparam logic [1:0] WRAP_64 = 2'd1;
    localparam logic [1:0] WRAP_76 = 2'd2;

    localparam logic [6:0] LINE_64  = 7'd64;
    localparam logic [6:0] LINE_76  = 7'd76;
    localparam logic [6:0] LINE_MAX = 7'd127;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;

    typedef struct packed {
        logic [7:0] char_62;
        logic [7:0] char_63;
        logic       pad_en;
        logic [1:0] wrap_mode;
    } cfg_t;

    // One queued word group: characters go out from index 0 upward.
    typedef struct packed {
        logic [2:0]               count;
        logic [MAX_CHARS-1:0][7:0] chars;
    } job_t;

    function automatic logic [7:0] sym(input logic [5:0] v, input cfg_t cfg);
        logic [7:0] r;
        if (v < 6'd26)
            r = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            r = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            r = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            r = cfg.char_62;
        else
            r = cfg.char_63;
        return r;
    endfunction

endpackage

// ----- hw/rtl/b64e_front.sv -----
// Front end: takes input bytes, tracks group and line state, builds char groups.
module b64e_front (
    input  logic              clk,
    input  logic              rst_n,
    input  b64e_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              q_full,
    output logic              push,
    output b64e_pkg::job_t    push_job
);
    import b64e_pkg::*;

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [5:0] carry_reg, carry_next;
    logic [6:0] line_reg, line_next;

    logic       wrap_due;
    logic [2:0] n;
    logic [1:0] inc;
    logic [6:0] lc;
    logic [7:0] lc_sum;
    job_t       job;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign push_job = job;

    always_comb
    begin
        wrap_due   = ((cfg.wrap_mode == WRAP_64) && (line_reg >= LINE_64)) ||
                     ((cfg.wrap_mode == WRAP_76) && (line_reg >= LINE_76));
        job        = '0;
        n          = 3'd0;
        inc        = 2'd1;
        lc         = line_reg;
        phase_next = PH_0;
        carry_next = 6'd0;

        if (wrap_due)
        begin
            job.chars[n] = CHAR_CR;
            n            = n + 3'd1;
            job.chars[n] = CHAR_LF;
            n            = n + 3'd1;
            lc           = 7'd0;
        end

        unique case (phase_reg)
            PH_1:
            begin
                job.chars[n] = sym(carry_reg | {2'b00, data_byte[7:4]}, cfg);
                n            = n + 3'd1;
                carry_next   = {data_byte[3:0], 2'b00};
                phase_next   = PH_2;
            end
            PH_2:
            begin
                job.chars[n] = sym(carry_reg | {4'd0, data_byte[7:6]}, cfg);
                n            = n + 3'd1;
                job.chars[n] = sym(data_byte[5:0], cfg);
                n            = n + 3'd1;
                inc          = 2'd2;
                carry_next   = 6'd0;
                phase_next   = PH_0;
            end
            default:
            begin
                // phase three never arises; handled like phase zero
                job.chars[n] = sym(data_byte[7:2], cfg);
                n            = n + 3'd1;
                carry_next   = {data_byte[1:0], 4'd0};
                phase_next   = PH_1;
            end
        endcase

        lc_sum    = {1'b0, lc} + {6'd0, inc};
        line_next = (lc_sum > {1'b0, LINE_MAX}) ? LINE_MAX : lc_sum[6:0];

        if (last_byte)
        begin
            // flush: no wrap check here, even on a full line
            if (phase_next != PH_0)
            begin
                job.chars[n] = sym(carry_next, cfg);
                n            = n + 3'd1;
                if (cfg.pad_en)
                begin
                    job.chars[n] = CHAR_PAD;
                    n            = n + 3'd1;
                    if (phase_next == PH_1)
                    begin
                        job.chars[n] = CHAR_PAD;
                        n            = n + 3'd1;
                    end
                end
            end
            phase_next = PH_0;
            carry_next = 6'd0;
            line_next  = 7'd0;
        end

        job.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            carry_reg <= 6'd0;
            line_reg  <= 7'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
            line_reg  <= line_next;
        end
    end

endmodule

// ----- hw/rtl/b64e_queue.sv -----
// Small FIFO of char groups between front and back.
`include "assert_macros.svh"

module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64e_pkg::job_t push_job,
    input  logic           pop,
    output logic           q_valid,
    output logic           q_full,
    output b64e_pkg::job_t pop_job
);
    import b64e_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign q_valid = (cnt_reg != '0);
    assign q_full  = (cnt_reg == FULL_CNT);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    `B64E_NEVER(a_q_overflow, clk, rst_n, push && q_full)
    `B64E_NEVER(a_q_underflow, clk, rst_n, pop && !q_valid)
    `B64E_ASSERT(a_q_count_range, clk, rst_n, cnt_reg <= FULL_CNT)

endmodule

// ----- hw/rtl/b64e_back.sv -----
// Back end: streams queued char groups out one character per word.
`include "assert_macros.svh"

module b64e_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  b64e_pkg::job_t pop_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_char,
    output logic           run_end
);
    import b64e_pkg::*;

    job_t       cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       run_end_reg;

    logic       load;
    logic       last_char;

    assign load      = !out_valid_reg || !out_stall;
    assign last_char = (idx_reg == cur_reg.count - 3'd1);
    assign pop       = q_valid && (!cur_valid_reg || (load && last_char));

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_end   = run_end_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
        else if (cur_valid_reg && load)
        begin
            idx_next = idx_reg + 3'd1;
            if (last_char)
                cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= pop_job;
        if (cur_valid_reg && load)
        begin
            out_char_reg <= cur_reg.chars[idx_reg];
            run_end_reg  <= last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (load)
                out_valid_reg <= cur_valid_reg;
        end
    end

    `B64E_ASSERT(a_idx_in_group, clk, rst_n,
                 cur_valid_reg |-> (cur_reg.count != 3'd0 && idx_reg < cur_reg.count))
    `B64E_ASSERT(a_pop_when_free, clk, rst_n,
                 pop |-> (!cur_valid_reg || (load && last_char)))
    `B64E_ASSERT(a_run_end_marked, clk, rst_n,
                 (cur_valid_reg && load && last_char) |=> (out_valid_reg && run_end_reg))

endmodule

// ----- hw/rtl/base64_stream_encoder_top.sv -----
// Top level of the streaming base64 encoder with optional line wrap.
//
// Input channel: in_valid / in_stall carry one message byte per word
// (data_byte, last_byte marks the final byte of a message).
// Output channel: out_valid / out_stall carry one character per word
// (out_char, run_end marks the last character caused by one input byte).
// Config: cfg_we writes cfg_data into register cfg_index (0 char for 62,
// 1 char for 63, 2 pad enable, 3 wrap mode); write only while idle.
// The output port moves one character per cycle while out_stall is low;
// a byte yields one to six characters (about 1.33 on average plus CR LF at
// line ends and padding at message end), so the output port is the limit.
// A byte is taken every cycle while the group queue (QUEUE_DEPTH entries)
// has room, so in_stall rises only when the queue fills behind a slow or
// stalled receiver. A stalled character holds.
// Reset clears group phase, carried bits, line count, queue and output,
// and loads the config defaults ('+', '/', padding on, no wrap).
module base64_stream_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_end,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import b64e_pkg::*;

    cfg_t cfg_reg;
    job_t push_job;
    job_t pop_job;
    logic push;
    logic pop;
    logic q_valid;
    logic q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.char_62   <= 8'd43;
            cfg_reg.char_63   <= 8'd47;
            cfg_reg.pad_en    <= 1'b1;
            cfg_reg.wrap_mode <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHAR_62: cfg_reg.char_62   <= cfg_data;
                REG_CHAR_63: cfg_reg.char_63   <= cfg_data;
                REG_PAD_EN:  cfg_reg.pad_en    <= cfg_data[0];
                REG_WRAP:    cfg_reg.wrap_mode <= cfg_data[1:0];
                default:     cfg_reg.pad_en    <= cfg_reg.pad_en;
            endcase
        end
    end

    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .pop_job  (pop_job)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .pop_job   (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .run_end   (run_end)
    );

endmodule
